[rtl/plc_pkg.sv]
// Package for the positional byte list: command and status codes, and the
// control word broadcast to every cell of the storage row.
// No dependencies.
package plc_pkg;

  localparam logic [3:0] CMD_CREATE        = 4'd0;
  localparam logic [3:0] CMD_ADD_FIRST     = 4'd1;
  localparam logic [3:0] CMD_ADD_LAST      = 4'd2;
  localparam logic [3:0] CMD_ADD_MIDDLE    = 4'd3;
  localparam logic [3:0] CMD_REMOVE_FIRST  = 4'd4;
  localparam logic [3:0] CMD_REMOVE_LAST   = 4'd5;
  localparam logic [3:0] CMD_REMOVE_MIDDLE = 4'd6;
  localparam logic [3:0] CMD_SEARCH        = 4'd7;
  localparam logic [3:0] CMD_LIST_ALL      = 4'd8;

  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_RANGE      = 3'd1;
  localparam logic [2:0] STAT_NOT_MIDDLE = 3'd2;
  localparam logic [2:0] STAT_FULL       = 3'd3;
  localparam logic [2:0] STAT_EMPTY      = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    logic [7:0] value;
  } cell_ctl_t;

endpackage

[rtl/plc_cell.sv]
// One storage cell of the list row: holds a single byte and takes a new one
// from itself, a neighbour, the front cell or the broadcast value.
// Depends on plc_pkg.
module plc_cell
  import plc_pkg::*;
#(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic            clk,
  input  cell_ctl_t       ctl,
  input  logic [IW-1:0]   k,
  input  logic [IW-1:0]   wrap,
  input  logic [7:0]      left,
  input  logic [7:0]      right,
  input  logic [7:0]      head,
  output logic [7:0]      data
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [7:0] data_next;

  always_comb begin
    data_next = data;
    case (ctl.op)
      CELL_INSERT: begin
        if (MY_IDX == k) data_next = ctl.value;
        else if (MY_IDX > k) data_next = left;
      end
      CELL_REMOVE: begin
        if (MY_IDX >= k) data_next = right;
      end
      CELL_ROTATE: begin
        // The occupied part turns one place towards the front; the front
        // byte wraps round to the last occupied cell.
        if (MY_IDX == wrap) data_next = head;
        else if (MY_IDX < wrap) data_next = right;
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[rtl/plc_row.sv]
// Row of DEPTH list cells, each linked to its neighbours; cell 0 is the
// front of the list and its byte is presented as head.
// Depends on plc_pkg and plc_cell.
module plc_row
  import plc_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic            clk,
  input  cell_ctl_t       ctl,
  input  logic [IW-1:0]   k,
  input  logic [IW-1:0]   wrap,
  output logic [7:0]      head
);

  logic [7:0] cells [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [7:0] left;
    logic [7:0] right;
    if (i == 0) begin : g_first
      assign left = 8'd0;
    end else begin : g_inner_l
      assign left = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = 8'd0;
    end else begin : g_inner_r
      assign right = cells[i+1];
    end
    plc_cell #(.IW(IW), .IDX(i)) u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .k     (k),
      .wrap  (wrap),
      .left  (left),
      .right (right),
      .head  (cells[0]),
      .data  (cells[i])
    );
  end

  assign head = cells[0];

endmodule

[rtl/positional_char_list.sv]
// Positional byte list: command decode, length counter, scan sequencer and
// output register around a row of shifting cells.
// Depends on plc_pkg and plc_row.
//
//   channel | dir | fields (tdata / tuser, lowest bit first)
//   s_*     | in  | tdata: value[7:0], position[15:8]; tuser: command[3:0]
//   m_*     | out | tdata: status[2:0], found[3], count[8:4], item[16:9];
//           |     | tlast: last_item
//
// Inserts, removals, create and unknown commands are done on acceptance: the
// whole row shifts at once and the result is registered in the same edge.
// Search and list_all latch the command when it is accepted and then rotate
// the row one place per cycle until every occupied byte has passed the front
// (an empty list is answered on acceptance); list_all gives a transfer per step.
// A new command is taken when the sequencer is idle and the output register
// is empty or being drained. A stalled output holds the rotation.
// Reset (rst, synchronous) empties the list; the cell bytes are not cleared.
module positional_char_list
  import plc_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // value[7:0], position[15:8]
  input  logic [3:0]  s_tuser,  // command[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // status[2:0], found[3], count[8:4], item[16:9]
  output logic        m_tlast
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_LEN = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_LEN  = CW'(1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LIST = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;

  logic [1:0]    state, state_next;
  logic [CW-1:0] length, length_next;
  logic [IW-1:0] cnt, cnt_next;
  logic [7:0]    srch_val, srch_val_next;
  logic          found, found_next;

  logic          out_valid, out_valid_next;
  logic [2:0]    out_status, out_status_next;
  logic          out_found, out_found_next;
  logic [4:0]    out_count, out_count_next;
  logic [7:0]    out_item, out_item_next;
  logic          out_last, out_last_next;

  cell_ctl_t     ctl;
  logic [IW-1:0] k;
  logic [IW-1:0] wrap;
  logic [7:0]    head;

  logic       out_free;
  logic       accept;
  logic [3:0] cmd;
  logic [7:0] value;
  logic [7:0] pos;
  logic       is_full;
  logic       is_empty;
  logic       pos_range;
  logic       pos_first;
  logic       scan_last;
  logic       hit;

  plc_row #(.DEPTH(DEPTH), .IW(IW)) u_row (
    .clk  (clk),
    .ctl  (ctl),
    .k    (k),
    .wrap (wrap),
    .head (head)
  );

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  assign cmd   = s_tuser;
  assign value = s_tdata[7:0];
  assign pos   = s_tdata[15:8];

  assign is_full   = (length == FULL_LEN);
  assign is_empty  = (length == '0);
  assign pos_range = (pos == 8'd0) || (pos > 8'(length));
  assign pos_first = (pos == 8'd1);
  assign wrap      = IW'(length - ONE_LEN);
  assign scan_last = (cnt == wrap);
  assign hit       = found || (head == srch_val);

  always_comb begin
    state_next      = state;
    length_next     = length;
    cnt_next        = cnt;
    srch_val_next   = srch_val;
    found_next      = found;
    out_valid_next  = out_valid && !m_tready;
    out_status_next = out_status;
    out_found_next  = out_found;
    out_count_next  = out_count;
    out_item_next   = out_item;
    out_last_next   = out_last;
    ctl.op          = CELL_HOLD;
    ctl.value       = value;
    k               = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          out_valid_next  = 1'b1;
          out_status_next = STAT_OK;
          out_found_next  = 1'b0;
          out_item_next   = 8'd0;
          out_last_next   = 1'b1;
          case (cmd)
            CMD_CREATE: begin
              ctl.op      = CELL_INSERT;
              length_next = ONE_LEN;
            end
            CMD_ADD_FIRST: begin
              if (is_full) out_status_next = STAT_FULL;
              else begin
                ctl.op      = CELL_INSERT;
                length_next = length + ONE_LEN;
              end
            end
            CMD_ADD_LAST: begin
              if (is_full) out_status_next = STAT_FULL;
              else begin
                ctl.op      = CELL_INSERT;
                k           = IW'(length);
                length_next = length + ONE_LEN;
              end
            end
            CMD_ADD_MIDDLE: begin
              if (is_full) out_status_next = STAT_FULL;
              else if (pos_range) out_status_next = STAT_RANGE;
              else if (pos_first) out_status_next = STAT_NOT_MIDDLE;
              else begin
                ctl.op      = CELL_INSERT;
                k           = IW'(pos - 8'd1);
                length_next = length + ONE_LEN;
              end
            end
            CMD_REMOVE_FIRST: begin
              if (is_empty) out_status_next = STAT_EMPTY;
              else begin
                ctl.op      = CELL_REMOVE;
                length_next = length - ONE_LEN;
              end
            end
            CMD_REMOVE_LAST: begin
              // The last cell simply falls outside the occupied part.
              if (is_empty) out_status_next = STAT_EMPTY;
              else length_next = length - ONE_LEN;
            end
            CMD_REMOVE_MIDDLE: begin
              if (is_empty) out_status_next = STAT_EMPTY;
              else if (pos_range) out_status_next = STAT_RANGE;
              else if (pos_first) out_status_next = STAT_NOT_MIDDLE;
              else begin
                ctl.op      = CELL_REMOVE;
                k           = IW'(pos - 8'd1);
                length_next = length - ONE_LEN;
              end
            end
            CMD_SEARCH: begin
              if (!is_empty) begin
                out_valid_next = 1'b0;
                state_next     = S_SRCH;
                cnt_next       = '0;
                found_next     = 1'b0;
                srch_val_next  = value;
              end
            end
            CMD_LIST_ALL: begin
              if (!is_empty) begin
                out_valid_next = 1'b0;
                state_next     = S_LIST;
                cnt_next       = '0;
              end
            end
            default: begin
            end
          endcase
          out_count_next = 5'(length_next);
        end
      end

      S_LIST: begin
        if (out_free) begin
          ctl.op          = CELL_ROTATE;
          cnt_next        = cnt + IW'(1);
          out_valid_next  = 1'b1;
          out_status_next = STAT_OK;
          out_found_next  = 1'b0;
          out_count_next  = 5'(length);
          out_item_next   = head;
          out_last_next   = scan_last;
          if (scan_last) state_next = S_IDLE;
        end
      end

      S_SRCH: begin
        if (out_free) begin
          ctl.op     = CELL_ROTATE;
          cnt_next   = cnt + IW'(1);
          found_next = hit;
          if (scan_last) begin
            out_valid_next  = 1'b1;
            out_status_next = STAT_OK;
            out_found_next  = hit;
            out_count_next  = 5'(length);
            out_item_next   = 8'd0;
            out_last_next   = 1'b1;
            state_next      = S_IDLE;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      length    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      length    <= length_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt        <= cnt_next;
    srch_val   <= srch_val_next;
    found      <= found_next;
    out_status <= out_status_next;
    out_found  <= out_found_next;
    out_count  <= out_count_next;
    out_item   <= out_item_next;
    out_last   <= out_last_next;
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_item, out_count, out_found, out_status};
  assign m_tlast  = out_last;

endmodule
